// ===== rtl/bcs_pkg.sv =====
// Shared types and constants of the Bezier curve sampler.
package bcs_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned SampleW  = 7;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned TW       = 17;
  localparam int unsigned WeightW  = 33;
  localparam int unsigned QuoW     = 23;
  localparam logic [TW-1:0] OneQ16 = 17'h10000;
  localparam logic [SampleW-1:0] SampleReset = 7'd64;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] curve_x;
    logic signed [CoordW-1:0] curve_y;
    logic signed [CoordW-1:0] curve_z;
    logic [IndexW-1:0]        sample_index;
    logic                     last_sample;
    logic                     point_dropped;
  } sample_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic            start;
    logic [QuoW-1:0] dividend;
    logic [IndexW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic     busy;
    logic [TW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/bcs_if.sv =====
// Valid/ready channel interfaces for control points and curve samples.
interface bcs_point_if;
  logic            valid;
  logic            ready;
  bcs_pkg::point_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bcs_sample_if;
  logic             valid;
  logic             ready;
  bcs_pkg::sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bcs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module bcs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/bcs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the sample parameter t.
module bcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcs_pkg::div_req_t req_i,
  output bcs_pkg::div_rsp_t rsp_o
);
  localparam int unsigned N    = bcs_pkg::QuoW;
  localparam int unsigned CntW = $clog2(N + 1);

  logic [N-1:0]   quo_q;
  logic [bcs_pkg::IndexW:0] rem_q;
  logic [bcs_pkg::IndexW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic [bcs_pkg::IndexW+1:0] trial;

  assign trial = {rem_q, quo_q[N-1]} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= CntW'(N);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      // Remainder stays below the divisor, so one trial subtract per bit.
      if (!trial[bcs_pkg::IndexW+1]) begin
        rem_q <= trial[bcs_pkg::IndexW:0];
        quo_q <= {quo_q[N-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[bcs_pkg::IndexW-1:0], quo_q[N-1]};
        quo_q <= {quo_q[N-2:0], 1'b0};
      end
    end
  end

  // The full quotient can reach 2^17 + 1, so the halved value is returned.
  assign rsp_o.busy     = (cnt_q != '0) || req_i.start;
  assign rsp_o.quotient = quo_q[bcs_pkg::TW:1];
endmodule

// ===== rtl/bezier_curve_sampler.sv =====
// Top level of the Bezier curve sampler: point store, sequencer and shared MAC.
//
// Usage: each request on point_in adds one signed Q12.12 control point to a
// store of MaxPoints entries, then sample_count curve samples (clamped to
// 2..MaxSamples) leave on sample_out in order of sample_index, the final one
// marked by last_sample. With a full store the point is dropped, every
// sample carries point_dropped, and the unchanged curve is sent again.
// Sequencing: point_in is not ready while an item is at work. For each
// sample the block starts the divider for t and waits on it, loads the
// weights, then the one shared multiplier builds the Bernstein weights
// level by level, one weight per pass through StWMulU, StWMulT and
// StWStore, then reads and sums each stored point in StAccRead, StAccX,
// StAccY and StAccZ, and emits through StEmit and StOut. point_in is
// ready again once the final sample of the item has left StOut.
// With many points the weight recurrence on the single multiplier dominates.
// A stalled receiver holds the sample register; the sequencer waits on it.
// Reset empties the store (point count zero) and sets sample_count to 64.
// sample_count_we_i writes the register; write it only while idle.
module bezier_curve_sampler #(
  parameter int unsigned MaxPoints  = 16,
  parameter int unsigned MaxSamples = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_count_we_i,
  input  logic [bcs_pkg::SampleW-1:0]   sample_count_i,
  bcs_point_if.sink                     point_in,
  bcs_sample_if.source                  sample_out
);
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned CW    = bcs_pkg::CoordW;
  localparam int unsigned WW    = bcs_pkg::WeightW;
  localparam int unsigned AccW  = CW + WW + CntW + 1;

  typedef enum logic [3:0] {
    StIdle, StDiv, StDivWait, StWLoad, StWMulU, StWMulT, StWStore,
    StAccRead, StAccX, StAccY, StAccZ, StEmit, StOut
  } state_e;

  state_e state_q;
  logic [bcs_pkg::SampleW-1:0] cfg_q;
  logic [CntW-1:0]   count_q;
  logic [AddrW-1:0]  j_q;
  logic [CntW-1:0]   m_q;
  logic [bcs_pkg::IndexW-1:0] k_q, last_k_q;
  logic              dropped_q;
  logic [bcs_pkg::TW-1:0] t_q, u_q;
  logic [WW-1:0]     w_q [MaxPoints];
  logic [WW+bcs_pkg::TW:0] wsum_q;
  logic [WW-1:0]     prev_q;
  logic signed [AccW-1:0] ax_q, ay_q, az_q;
  logic signed [WW+CW+1:0] prod;
  logic [WW+bcs_pkg::TW-1:0] uprod;
  logic [WW-1:0]     mul_w;
  logic signed [CW:0] mul_b;
  bcs_pkg::sample_t  out_q;
  logic              out_valid_q;
  logic              load_out;
  bcs_pkg::div_req_t div_req;
  bcs_pkg::div_rsp_t div_rsp;
  logic              we;
  logic [CW-1:0]     rx, ry, rz;
  logic [AddrW-1:0]  raddr;
  logic [CntW-1:0]   npts;

  assign we = point_in.valid && point_in.ready && (count_q < CntW'(MaxPoints));
  assign npts = count_q;

  bcs_ram #(.Width(CW), .Depth(MaxPoints)) u_ram_x (
    .clk_i, .we_i(we), .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(point_in.payload.point_x), .raddr_i(raddr), .rdata_o(rx));
  bcs_ram #(.Width(CW), .Depth(MaxPoints)) u_ram_y (
    .clk_i, .we_i(we), .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(point_in.payload.point_y), .raddr_i(raddr), .rdata_o(ry));
  bcs_ram #(.Width(CW), .Depth(MaxPoints)) u_ram_z (
    .clk_i, .we_i(we), .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(point_in.payload.point_z), .raddr_i(raddr), .rdata_o(rz));

  bcs_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign raddr = j_q;

  // The single shared multiplier: weight times t/u, or weight times coordinate.
  always_comb begin
    mul_w = w_q[j_q];
    mul_b = {{(CW + 1 - bcs_pkg::TW){1'b0}}, t_q};
    unique case (state_q)
      StWMulU: begin
        mul_b = {{(CW + 1 - bcs_pkg::TW){1'b0}}, u_q};
      end
      StWMulT: begin
        mul_w = prev_q;
      end
      StAccX: begin
        mul_b = {rx[CW-1], rx};
      end
      StAccY: begin
        mul_b = {ry[CW-1], ry};
      end
      StAccZ: begin
        mul_b = {rz[CW-1], rz};
      end
      default: ;
    endcase
  end

  assign prod  = $signed({1'b0, mul_w}) * mul_b;
  assign uprod = prod[WW+bcs_pkg::TW-1:0];

  assign point_in.ready   = (state_q == StIdle);
  assign sample_out.valid = out_valid_q;
  assign sample_out.payload = out_q;
  assign load_out = (state_q == StEmit) && (!out_valid_q || sample_out.ready);

  function automatic logic [CW-1:0] round_sat(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] r;
    r = (a + AccW'(64'sd1 << (WW - 2))) >>> (WW - 1);
    if (r > AccW'(8388607)) return 24'h7FFFFF;
    if (r < -AccW'(8388608)) return 24'h800000;
    return r[CW-1:0];
  endfunction

  always_comb begin
    div_req.start    = (state_q == StDiv);
    div_req.dividend = {k_q, 16'h0, 1'b0} + bcs_pkg::QuoW'(last_k_q);
    div_req.divisor  = last_k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_q       <= bcs_pkg::SampleReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_count_we_i) cfg_q <= sample_count_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (sample_out.valid && sample_out.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (point_in.valid) begin
            dropped_q <= !we;
            if (we) count_q <= count_q + 1'b1;
            k_q <= '0;
            if (cfg_q < 7'd2) last_k_q <= 6'd1;
            else if (cfg_q > bcs_pkg::SampleW'(MaxSamples))
              last_k_q <= bcs_pkg::IndexW'(MaxSamples - 1);
            else last_k_q <= bcs_pkg::IndexW'(cfg_q - 1'b1);
            state_q <= StDiv;
          end
        end
        StDiv: state_q <= StDivWait;
        StDivWait: begin
          if (!div_rsp.busy) begin
            // Half of (2k*65536 + den) / den, which rounds k*65536/den to nearest.
            t_q <= div_rsp.quotient;
            state_q <= StWLoad;
          end
        end
        StWLoad: begin
          t_q <= (t_q > bcs_pkg::OneQ16) ? bcs_pkg::OneQ16 : t_q;
          u_q <= bcs_pkg::OneQ16 - ((t_q > bcs_pkg::OneQ16) ? bcs_pkg::OneQ16 : t_q);
          w_q[0] <= WW'(1) << (WW - 1);
          m_q <= CntW'(1);
          j_q <= AddrW'(1);
          prev_q <= WW'(1) << (WW - 1);
          ax_q <= '0; ay_q <= '0; az_q <= '0;
          state_q <= (npts > CntW'(1)) ? StWMulU : StAccRead;
          if (npts <= CntW'(1)) j_q <= '0;
        end
        StWMulU: begin
          // At j == m the current weight is the zero above the last level.
          wsum_q <= (CntW'(j_q) == m_q) ? '0 : (WW + bcs_pkg::TW + 1)'(uprod);
          state_q <= StWMulT;
        end
        StWMulT: begin
          wsum_q <= wsum_q + (WW + bcs_pkg::TW + 1)'(uprod) + 32768;
          state_q <= StWStore;
        end
        StWStore: begin
          w_q[j_q] <= WW'(wsum_q >> 16);
          if (j_q == '0) begin
            if (m_q + 1'b1 == npts) begin
              state_q <= StAccRead;
            end else begin
              m_q <= m_q + 1'b1;
              j_q <= AddrW'(m_q + 1'b1);
              prev_q <= w_q[AddrW'(m_q)];
              state_q <= StWMulU;
            end
          end else begin
            j_q <= j_q - 1'b1;
            prev_q <= (j_q - 1'b1 == '0) ? '0 : w_q[j_q - 2'd2];
            state_q <= StWMulU;
          end
        end
        StAccRead: state_q <= StAccX;
        StAccX: begin
          ax_q <= ax_q + AccW'(prod);
          state_q <= StAccY;
        end
        StAccY: begin
          ay_q <= ay_q + AccW'(prod);
          state_q <= StAccZ;
        end
        StAccZ: begin
          az_q <= az_q + AccW'(prod);
          if (CntW'(j_q) + 1'b1 == npts) begin
            state_q <= StEmit;
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= StAccRead;
          end
        end
        StEmit: begin
          if (load_out) begin
            out_q.curve_x <= round_sat(ax_q);
            out_q.curve_y <= round_sat(ay_q);
            out_q.curve_z <= round_sat(az_q);
            out_q.sample_index <= k_q;
            out_q.last_sample <= (k_q == last_k_q);
            out_q.point_dropped <= dropped_q;
            state_q <= StOut;
          end
        end
        StOut: begin
          if (k_q == last_k_q) begin
            state_q <= StIdle;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= StDiv;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== bench/bcs_curve_checker.sv =====
// Checker for the Bezier curve sampler: predicts every curve sample and compares.
module bcs_curve_checker #(
  parameter int unsigned MaxPoints  = 16,
  parameter int unsigned MaxSamples = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sample_count_we_i,
  input  logic [bcs_pkg::SampleW-1:0] sample_count_i,
  bcs_point_if                        point_in,
  bcs_sample_if                       sample_out,
  output int                          pending_o,
  output int                          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [bcs_pkg::CoordW-1:0] store_x[MaxPoints];
  logic signed [bcs_pkg::CoordW-1:0] store_y[MaxPoints];
  logic signed [bcs_pkg::CoordW-1:0] store_z[MaxPoints];
  int unsigned                       stored_points;
  logic [bcs_pkg::SampleW-1:0]       samples_reg;
  bcs_pkg::sample_t                  curve_q[$];

  function automatic logic signed [bcs_pkg::CoordW-1:0] round_sat(longint acc);
    longint r;
    r = (acc + 64'sd2147483648) >>> 32;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[bcs_pkg::CoordW-1:0];
  endfunction

  // Queues every sample of the curve through the stored points.
  function automatic void predict_curve(logic dropped);
    int unsigned      s;
    longint unsigned  t;
    longint unsigned  u;
    longint unsigned  bern[MaxPoints];
    longint unsigned  prev;
    longint unsigned  cur;
    longint           ax;
    longint           ay;
    longint           az;
    bcs_pkg::sample_t smp;
    s = samples_reg;
    if (s < 2) s = 2;
    if (s > MaxSamples) s = MaxSamples;
    for (int unsigned k = 0; k < s; k++) begin
      t = (longint'(k) * 65536 + (s - 1) / 2) / (s - 1);
      if (t > 65536) t = 65536;
      u = 65536 - t;
      foreach (bern[i]) bern[i] = 0;
      bern[0] = 64'd1 << 32;
      for (int m = 1; m < int'(stored_points); m++) begin
        for (int j = m; j >= 0; j--) begin
          prev = (j > 0) ? bern[j-1] : 0;
          cur = (j < m) ? bern[j] : 0;
          bern[j] = (u * cur + t * prev + 32768) >> 16;
        end
      end
      ax = 0;
      ay = 0;
      az = 0;
      for (int j = 0; j < int'(stored_points); j++) begin
        ax += longint'(store_x[j]) * longint'(bern[j]);
        ay += longint'(store_y[j]) * longint'(bern[j]);
        az += longint'(store_z[j]) * longint'(bern[j]);
      end
      smp.curve_x = round_sat(ax);
      smp.curve_y = round_sat(ay);
      smp.curve_z = round_sat(az);
      smp.sample_index = k[bcs_pkg::IndexW-1:0];
      smp.last_sample = (k == s - 1);
      smp.point_dropped = dropped;
      curve_q.insert(curve_q.size(), smp);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bcs_pkg::sample_t exp_s;
    bcs_pkg::sample_t got;
    if (!rst_ni) begin
      stored_points = 0;
      samples_reg = bcs_pkg::SampleReset;
      curve_q.delete();
      fail_count_o = 0;
    end else begin
      if (sample_count_we_i) samples_reg = sample_count_i;
      if (point_in.valid && point_in.ready) begin
        if (stored_points < MaxPoints) begin
          store_x[stored_points] = point_in.payload.point_x;
          store_y[stored_points] = point_in.payload.point_y;
          store_z[stored_points] = point_in.payload.point_z;
          stored_points++;
          predict_curve(1'b0);
        end else begin
          predict_curve(1'b1);
        end
      end
      if (sample_out.valid && sample_out.ready) begin
        got = sample_out.payload;
        if (curve_q.size() == 0) begin
          $display("%0t: unexpected sample: got %p", $time, got);
          fail_count_o++;
        end else begin
          exp_s = curve_q.pop_front();
          if (got.curve_x !== exp_s.curve_x || got.curve_y !== exp_s.curve_y ||
              got.curve_z !== exp_s.curve_z || got.sample_index !== exp_s.sample_index ||
              got.last_sample !== exp_s.last_sample ||
              got.point_dropped !== exp_s.point_dropped) begin
            $display("%0t: sample mismatch: expected %p, actual %p", $time, exp_s, got);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = curve_q.size();
  end
endmodule

// ===== bench/tb_bezier_curve_sampler.sv =====
// Top of the Bezier curve sampler bench: stimulus, idling, watchdog and verdict.
module tb_bezier_curve_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned StallLimit = 100000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        sample_count_we;
  logic [bcs_pkg::SampleW-1:0] sample_count;
  int                          pending;
  int                          fail_count;
  int                          tx_idle_pct;
  int                          rx_idle_pct;
  int                          quiet_cycles;

  bcs_point_if  point_in ();
  bcs_sample_if sample_out ();

  bezier_curve_sampler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_count_we_i (sample_count_we),
    .sample_count_i    (sample_count),
    .point_in          (point_in.sink),
    .sample_out        (sample_out.source)
  );

  bcs_curve_checker #(.MaxPoints(MaxPoints)) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_count_we_i (sample_count_we),
    .sample_count_i    (sample_count),
    .point_in          (point_in),
    .sample_out        (sample_out),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    sample_out.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((point_in.valid && point_in.ready) || (sample_out.valid && sample_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [bcs_pkg::CoordW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return '0;
      3: return bcs_pkg::CoordW'($urandom_range(8192)) - 24'sd4096;
      default: return bcs_pkg::CoordW'($urandom);
    endcase
  endfunction

  task automatic add_point(logic signed [bcs_pkg::CoordW-1:0] x,
                           logic signed [bcs_pkg::CoordW-1:0] y,
                           logic signed [bcs_pkg::CoordW-1:0] z);
    if ($urandom_range(99) < tx_idle_pct) begin
      point_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    point_in.valid <= 1'b1;
    point_in.payload <= '{point_x: x, point_y: y, point_z: z};
    do @(posedge clk_i); while (!point_in.ready);
  endtask

  // Holds off new requests until every expected sample has come out.
  task automatic drain();
    point_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_samples(logic [bcs_pkg::SampleW-1:0] value);
    drain();
    sample_count_we <= 1'b1;
    sample_count <= value;
    @(posedge clk_i);
    sample_count_we <= 1'b0;
  endtask

  task automatic random_points(int count);
    for (int i = 0; i < count; i++) begin
      add_point(rand_coord(), rand_coord(), rand_coord());
      if (i == count / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    sample_count_we <= 1'b0;
    sample_count <= bcs_pkg::SampleReset;
    point_in.valid <= 1'b0;
    point_in.payload <= '0;
    tx_idle_pct = 22;
    rx_idle_pct = 59;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: coordinate extremes at the reset sample count, then counts
    // that clamp low, a full store and dropped points, and counts that clamp high.
    add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    add_point(-24'sh800000, -24'sh800000, -24'sh800000);
    add_point(24'sh7FFFFF, -24'sh800000, '0);
    add_point('0, 24'sh7FFFFF, -24'sh800000);
    set_samples(7'd0);
    add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    add_point(24'sh000001, -24'sh000001, 24'sh001000);
    set_samples(7'd1);
    add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    set_samples(7'd3);
    for (int i = 0; i < 9; i++) add_point(rand_coord(), rand_coord(), rand_coord());
    add_point(-24'sh800000, 24'sh7FFFFF, 24'sh000800);
    set_samples(7'd2);
    add_point(24'sh123456, 24'sh654321, -24'sh0ABCDE);
    set_samples(7'd127);
    add_point(rand_coord(), rand_coord(), rand_coord());
    set_samples(7'd65);
    add_point(rand_coord(), rand_coord(), rand_coord());
    set_samples(7'd64);
    add_point(rand_coord(), rand_coord(), rand_coord());

    // Random part in three idling modes, sample count changed between chunks.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 59 : 0;
      rx_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 22 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        set_samples(bcs_pkg::SampleW'($urandom_range(0, 10)));
        random_points(10);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
